@@ sv/amgs_pkg.sv @@
// types and codes shared by the graph store modules
package amgs_pkg;

   localparam int LABEL_W = 32;
   localparam int VCOUNT_W = 4;
   localparam int STATUS_W = 3;

   typedef logic signed [LABEL_W-1:0] label_type;

   typedef enum logic [1:0] {
      FUNC_INSERT     = 2'd0,
      FUNC_SET_EDGE   = 2'd1,
      FUNC_CLEAR_EDGE = 2'd2,
      FUNC_QUERY_EDGE = 2'd3
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 3'd0,
      STATUS_REFUSED   = 3'd1,
      STATUS_NO_ORIGIN = 3'd2,
      STATUS_NO_DEST   = 3'd3,
      STATUS_NO_BOTH   = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SEARCH,
      S_DECIDE,
      S_ROW_UPDATE,
      S_RESP
   } state_type;

   typedef struct packed {
      func_type  func;
      label_type first_label;
      label_type second_label;
   } req_type;

   typedef struct packed {
      status_type          status;
      logic                edge_present;
      logic [VCOUNT_W-1:0] vertex_count;
   } rsp_type;

   // result of one label compare, one slot per cycle
   typedef struct packed {
      logic valid;
      logic hit_first;
      logic hit_second;
   } match_type;

endpackage

@@ sv/amgs_label_table.sv @@
// label memory with one read port and the shared label comparator
module amgs_label_table #(
   parameter int MAX_VERTICES = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 wr_en,
   input  logic [$clog2(MAX_VERTICES)-1:0]      wr_addr,
   input  amgs_pkg::label_type                  wr_data,
   input  logic                                 rd_en,
   input  logic [$clog2(MAX_VERTICES)-1:0]      rd_addr,
   input  amgs_pkg::label_type                  key_first,
   input  amgs_pkg::label_type                  key_second,
   output amgs_pkg::match_type                  match
);
   import amgs_pkg::*;

   label_type label_mem [MAX_VERTICES];
   label_type rd_data_ff;
   logic      rd_vld_ff;
   logic      rd_vld_in;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         label_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= label_mem[rd_addr];
      end
   end

   assign rd_vld_in = rd_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= rd_vld_in;
      end
   end

   // raw bit-pattern compare against both endpoint keys
   always_comb begin
      match.valid      = rd_vld_ff;
      match.hit_first  = (rd_data_ff == key_first);
      match.hit_second = (rd_data_ff == key_second);
   end

endmodule

@@ sv/adjacency_matrix_graph_store_core.sv @@
// directed graph store: label table, search sequencer and edge bit matrix
// an accepted word passes through the search and decide steps, and also a row update
//    step when an edge command finds both labels, before rsp_valid is raised
// one command at a time: the next word is taken only after the result is taken
// the search reads one stored label per cycle, edge rows are read-modify-written once per set or clear
// synchronous active-high reset empties the table and invalidates all edge rows at once
module adjacency_matrix_graph_store_core #(
   parameter int MAX_VERTICES = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  amgs_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output amgs_pkg::rsp_type rsp_data
);
   import amgs_pkg::*;

   localparam int IDX_W = $clog2(MAX_VERTICES);
   localparam int CNT_W = $clog2(MAX_VERTICES + 1);
   localparam logic [CNT_W-1:0] FULL = CNT_W'(MAX_VERTICES);

   // sequencer state
   state_type state_ff, state_in;

   // command held for the whole operation
   req_type cmd_ff, cmd_in;

   // search counter and fill count
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;

   // search results: first matching slot of each endpoint
   logic             found_o_ff, found_o_in;
   logic             found_d_ff, found_d_in;
   logic [IDX_W-1:0] slot_o_ff, slot_o_in;
   logic [IDX_W-1:0] slot_d_ff, slot_d_in;

   // result word register
   rsp_type rsp_ff, rsp_in;

   // edge matrix: one row per origin slot, rows valid after first write
   logic [MAX_VERTICES-1:0] edge_mem [MAX_VERTICES];
   logic [MAX_VERTICES-1:0] row_rd_ff;
   logic                    row_ok_ff;
   logic [MAX_VERTICES-1:0] row_valid_ff, row_valid_in;
   logic [MAX_VERTICES-1:0] row_cur;
   logic [MAX_VERTICES-1:0] row_new;
   logic [MAX_VERTICES-1:0] dest_bit;

   // control strobes from the output decode
   logic search_rd;
   logic lbl_wr;
   logic row_wr;

   logic       search_more;
   logic       insert_ok;
   match_type  match;

   amgs_label_table #(
      .MAX_VERTICES(MAX_VERTICES)
   ) u_label_table (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (lbl_wr),
      .wr_addr    (fill_ff[IDX_W-1:0]),
      .wr_data    (cmd_ff.first_label),
      .rd_en      (search_rd),
      .rd_addr    (idx_ff[IDX_W-1:0]),
      .key_first  (cmd_ff.first_label),
      .key_second (cmd_ff.second_label),
      .match      (match)
   );

   assign search_more = (idx_ff != fill_ff);
   // a full table or an existing label refuses the insert
   assign insert_ok   = !found_o_ff && (fill_ff != FULL);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_SEARCH;
            end
         end
         S_SEARCH: begin
            // last compare lands on the edge that leaves this state
            if (!search_more) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (cmd_ff.func != FUNC_INSERT && found_o_ff && found_d_ff) begin
               state_in = S_ROW_UPDATE;
            end else begin
               state_in = S_RESP;
            end
         end
         S_ROW_UPDATE: begin
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // outputs and strobes
   always_comb begin
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      search_rd = 1'b0;
      lbl_wr    = 1'b0;
      row_wr    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
         end
         S_SEARCH: begin
            search_rd = search_more;
         end
         S_DECIDE: begin
            lbl_wr = (cmd_ff.func == FUNC_INSERT) && insert_ok;
         end
         S_ROW_UPDATE: begin
            row_wr = (cmd_ff.func inside {FUNC_SET_EDGE, FUNC_CLEAR_EDGE});
         end
         S_RESP: begin
            rsp_valid = 1'b1;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   assign rsp_data = rsp_ff;

   // row modify path
   always_comb begin
      row_cur = row_ok_ff ? row_rd_ff : '0;
      dest_bit = '0;
      dest_bit[slot_d_ff] = 1'b1;
      case (cmd_ff.func)
         FUNC_SET_EDGE:   row_new = row_cur | dest_bit;
         FUNC_CLEAR_EDGE: row_new = row_cur & ~dest_bit;
         default:         row_new = row_cur;
      endcase
   end

   // datapath next values
   always_comb begin
      cmd_in       = cmd_ff;
      idx_in       = idx_ff;
      fill_in      = fill_ff;
      rd_idx_in    = rd_idx_ff;
      found_o_in   = found_o_ff;
      found_d_in   = found_d_ff;
      slot_o_in    = slot_o_ff;
      slot_d_in    = slot_d_ff;
      rsp_in       = rsp_ff;
      row_valid_in = row_valid_ff;

      if (req_valid && req_ready) begin
         cmd_in     = req_data;
         idx_in     = '0;
         found_o_in = 1'b0;
         found_d_in = 1'b0;
      end

      if (search_rd) begin
         idx_in    = idx_ff + CNT_W'(1);
         rd_idx_in = idx_ff[IDX_W-1:0];
      end

      // first match wins for each endpoint
      if (match.valid) begin
         if (match.hit_first && !found_o_ff) begin
            found_o_in = 1'b1;
            slot_o_in  = rd_idx_ff;
         end
         if (match.hit_second && !found_d_ff) begin
            found_d_in = 1'b1;
            slot_d_in  = rd_idx_ff;
         end
      end

      if (lbl_wr) begin
         fill_in = fill_ff + CNT_W'(1);
      end

      if (state_ff == S_DECIDE) begin
         rsp_in.edge_present = 1'b0;
         rsp_in.vertex_count = VCOUNT_W'(fill_in);
         if (cmd_ff.func == FUNC_INSERT) begin
            rsp_in.status = insert_ok ? STATUS_OK : STATUS_REFUSED;
         end else if (!found_o_ff && !found_d_ff) begin
            rsp_in.status = STATUS_NO_BOTH;
         end else if (!found_o_ff) begin
            rsp_in.status = STATUS_NO_ORIGIN;
         end else if (!found_d_ff) begin
            rsp_in.status = STATUS_NO_DEST;
         end else begin
            rsp_in.status = STATUS_OK;
         end
      end

      if (state_ff == S_ROW_UPDATE) begin
         rsp_in.edge_present = (cmd_ff.func == FUNC_QUERY_EDGE) && row_cur[slot_d_ff];
      end

      if (row_wr) begin
         row_valid_in[slot_o_ff] = 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         found_o_ff   <= 1'b0;
         found_d_ff   <= 1'b0;
         idx_ff       <= '0;
         row_valid_ff <= '0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         found_o_ff   <= found_o_in;
         found_d_ff   <= found_d_in;
         idx_ff       <= idx_in;
         row_valid_ff <= row_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      rd_idx_ff <= rd_idx_in;
      slot_o_ff <= slot_o_in;
      slot_d_ff <= slot_d_in;
      rsp_ff    <= rsp_in;
   end

   // edge matrix port: row of the origin slot is read every cycle,
   // written back once in the update step of a set or clear command
   always_ff @(posedge clock) begin
      row_rd_ff <= edge_mem[slot_o_ff];
      row_ok_ff <= row_valid_ff[slot_o_ff];
      if (row_wr) begin
         edge_mem[slot_o_ff] <= row_new;
      end
   end

endmodule

@@ sv/amgs_checker.sv @@
// port-level checks for the graph store core, bound to the top level
module amgs_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input amgs_pkg::rsp_type rsp_data
);
   import amgs_pkg::*;

   // a pending result holds steady
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed while stalled");

   // one command at a time: busy right after a word is taken
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready && !rsp_valid)
      else $error("ready or result right after accept");

   // no new word while a result waits
   a_no_accept_with_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("ready while result pending");

   // back to idle once the result is taken
   a_idle_after_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |=> req_ready && !rsp_valid)
      else $error("not idle after result taken");

   // edge_present only on a successful command with a legal status
   a_present_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status == STATUS_OK || rsp_data.status == STATUS_REFUSED
                     || rsp_data.status == STATUS_NO_ORIGIN
                     || rsp_data.status == STATUS_NO_DEST
                     || rsp_data.status == STATUS_NO_BOTH)
                    && (!rsp_data.edge_present || rsp_data.status == STATUS_OK))
      else $error("bad status or edge flag");

endmodule

bind adjacency_matrix_graph_store_core amgs_checker u_amgs_checker (.*);
